/* design/scs_pkg.sv */
package scs_pkg;

  // Field and datapath widths
  localparam int COEFF_BITS     = 24;
  localparam int MAX_TRUNCATION = 63;
  localparam int TRUNC_BITS     = 6;
  localparam int IDX_BITS       = 13;
  localparam int COUNT_BITS     = IDX_BITS + 1;
  localparam int PROD_BITS      = 2 * COEFF_BITS;
  localparam int SUM_BITS       = 64;
  localparam int ROOT_BITS      = SUM_BITS / 2;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [IDX_BITS-1:0] IDX_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TRUNC_J = 2'd0,
    CFG_TRUNC_K = 2'd1,
    CFG_TRUNC_M = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNEQUAL = 2'd1,
    STATUS_COUNT   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COEFF_BITS-1:0] coeff_value;
    logic                         is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [COEFF_BITS-1:0] mean_value;
    logic [ROOT_BITS-1:0]         energy_norm;
    logic [ROOT_BITS-1:0]         std_dev;
    logic                         is_constant;
    logic [1:0]                   status;
  } out_item_t;

  // Commands from the sequencer to the square-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic add_twice;
    logic clear;
  } sqacc_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ1,
    S_ADD1,
    S_ADD2,
    S_MEAN,
    S_ROOT_E,
    S_WAIT_E,
    S_ROOT_S,
    S_WAIT_S,
    S_DONE
  } state_t;

endpackage

/* design/scs_sqacc.sv */
module scs_sqacc
  import scs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  sqacc_ctrl_t                  ctrl,
  input  logic signed [COEFF_BITS-1:0] operand,
  output logic [SUM_BITS-1:0]          acc,
  output logic [SUM_BITS-1:0]          acc_sum
);

  localparam int ACC_W = SUM_BITS + 1;

  logic signed [PROD_BITS-1:0] sq_full;
  logic [PROD_BITS-1:0]        prod;
  logic [ACC_W-1:0]            addend;
  logic [ACC_W-1:0]            sum_wide;

  // One shared squarer, registered before the adder
  assign sq_full = operand * operand;

  assign addend   = ctrl.add_twice ? ACC_W'({prod, 1'b0}) : ACC_W'(prod);
  assign sum_wide = ACC_W'(acc) + addend;
  // Saturate at all ones
  assign acc_sum  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_BITS'(sq_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add_en) begin
      acc <= acc_sum;
    end
  end

endmodule

/* design/scs_isqrt.sv */
module scs_isqrt
  import scs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SUM_BITS-1:0]  radicand,
  output logic                 done,
  output logic [ROOT_BITS-1:0] root
);

  localparam int CNT_BITS = $clog2(ROOT_BITS);
  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int TRY_BITS = REM_BITS + 2;
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(ROOT_BITS - 1);

  logic                busy;
  logic [CNT_BITS-1:0] step;
  logic [SUM_BITS-1:0] rad;
  logic [REM_BITS-1:0] rem;
  logic [TRY_BITS-1:0] rem_sh;
  logic [TRY_BITS-1:0] trial;
  logic                fits;

  // One result bit per cycle: bring down two radicand bits, try root*4+1
  assign rem_sh = {rem, rad[SUM_BITS-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[SUM_BITS-3:0], 2'b00};
      rem  <= fits ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
      root <= {root[ROOT_BITS-2:0], fits};
    end
  end

endmodule

/* design/spectral_coefficient_statistics_top.sv */
// Spectral statistics of one triangular-truncation coefficient set. Write
// trunc_j, trunc_k and trunc_m first, then stream the set one value per item
// (real part, then imaginary part of each coefficient, zonal ones first)
// with is_last on the final value. An ordinary value keeps busy high
// through S_SQ1, S_ADD1 and S_ADD2 after it is taken, since the single squarer
// and saturating adder serve both parts of a coefficient in turn. The last
// value of a set also runs the mean square and two bit-serial square roots
// on one shared root unit before done pulses; with an error status done
// follows S_ADD2 directly. After the done pulse, start is taken
// again in the next cycle. The result is shown for exactly one cycle while
// done is high and cannot be held off; capture it then. On error status the
// mean, both roots and the constant flag read zero.
module spectral_coefficient_statistics_top
  import scs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  in_item_t                in_data,
  output logic                    done,
  output out_item_t               result,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TRUNC_BITS-1:0]   cfg_data
);

  state_t state, state_next;

  logic [TRUNC_BITS-1:0] trunc_j;
  logic [TRUNC_BITS-1:0] trunc_k;
  logic [TRUNC_BITS-1:0] trunc_m;

  // Stream state
  logic [IDX_BITS-1:0]          value_index;
  logic signed [COEFF_BITS-1:0] first_value;
  logic signed [COEFF_BITS-1:0] real_part_held;

  // Item in progress
  logic signed [COEFF_BITS-1:0] cur_value;
  logic                         cur_last;
  logic                         cur_once;
  logic                         cur_pair;
  status_t                      cur_status;

  logic [ROOT_BITS-1:0] energy_root;
  logic [ROOT_BITS-1:0] std_root;

  logic                         accept;
  logic [IDX_BITS-2:0]          coeff_num;
  logic [COUNT_BITS-1:0]        count;
  logic [TRUNC_BITS:0]          m_p1;
  logic [TRUNC_BITS:0]          m_p2;
  logic [COUNT_BITS-1:0]        expected;
  status_t                      status_now;

  sqacc_ctrl_t                  sq_ctrl;
  logic signed [COEFF_BITS-1:0] sq_operand;
  logic [SUM_BITS-1:0]          square_sum;
  logic [SUM_BITS-1:0]          acc_sum;

  logic                sqrt_start;
  logic [SUM_BITS-1:0] sqrt_radicand;
  logic                sqrt_done;
  logic [ROOT_BITS-1:0] sqrt_root;

  logic result_ok;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Classify the incoming value
  assign coeff_num = value_index[IDX_BITS-1:1];
  assign count     = COUNT_BITS'(value_index) + 1'b1;
  assign m_p1      = (TRUNC_BITS+1)'(trunc_m) + 1'b1;
  assign m_p2      = (TRUNC_BITS+1)'(trunc_m) + 2'd2;
  assign expected  = COUNT_BITS'(m_p1) * COUNT_BITS'(m_p2);

  always_comb begin
    if (trunc_j != trunc_m || trunc_m != trunc_k) begin
      status_now = STATUS_UNEQUAL;
    end else if (int'(trunc_m) > MAX_TRUNCATION || count != expected) begin
      status_now = STATUS_COUNT;
    end else begin
      status_now = STATUS_OK;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trunc_j <= '0;
      trunc_k <= '0;
      trunc_m <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRUNC_J: trunc_j <= cfg_data;
        CFG_TRUNC_K: trunc_k <= cfg_data;
        CFG_TRUNC_M: trunc_m <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stream state: advance the index, keep the mean and the pending real part
  always_ff @(posedge clk) begin
    if (rst) begin
      value_index    <= '0;
      first_value    <= '0;
      real_part_held <= '0;
    end else if (accept) begin
      if (in_data.is_last) begin
        value_index <= '0;
      end else if (value_index != IDX_MAX) begin
        value_index <= value_index + 1'b1;
      end
      if (!value_index[0]) begin
        real_part_held <= in_data.coeff_value;
        if (value_index == '0) begin
          first_value <= in_data.coeff_value;
        end
      end
    end else if (state == S_DONE) begin
      first_value    <= '0;
      real_part_held <= '0;
    end
  end

  // Latch the item and its weighting with the current J
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_value  <= in_data.coeff_value;
      cur_last   <= in_data.is_last;
      cur_once   <= !value_index[0] && value_index != '0 &&
                    coeff_num <= (IDX_BITS-1)'(trunc_j);
      cur_pair   <= value_index[0] && coeff_num > (IDX_BITS-1)'(trunc_j);
      cur_status <= status_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: drive the shared squarer/adder and the root unit
  always_comb begin
    state_next    = state;
    sq_ctrl       = '0;
    sq_operand    = cur_value;
    sqrt_start    = 1'b0;
    sqrt_radicand = square_sum;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SQ1;
        end
      end
      S_SQ1: begin
        // Square the held real part first for an m>0 pair
        sq_ctrl.mul_en = 1'b1;
        sq_operand     = cur_pair ? real_part_held : cur_value;
        state_next     = S_ADD1;
      end
      S_ADD1: begin
        sq_ctrl.add_en    = cur_once || cur_pair;
        sq_ctrl.add_twice = cur_pair;
        sq_ctrl.mul_en    = 1'b1;
        sq_operand        = cur_value;
        state_next        = S_ADD2;
      end
      S_ADD2: begin
        sq_ctrl.add_en    = cur_pair;
        sq_ctrl.add_twice = 1'b1;
        if (!cur_last) begin
          state_next = S_IDLE;
        end else if (cur_status == STATUS_OK) begin
          state_next = S_MEAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MEAN: begin
        sq_ctrl.mul_en = 1'b1;
        sq_operand     = first_value;
        state_next     = S_ROOT_E;
      end
      S_ROOT_E: begin
        // Sum plus mean squared, saturated, without touching the sum
        sqrt_start    = 1'b1;
        sqrt_radicand = acc_sum;
        state_next    = S_WAIT_E;
      end
      S_WAIT_E: begin
        if (sqrt_done) begin
          state_next = S_ROOT_S;
        end
      end
      S_ROOT_S: begin
        sqrt_start = 1'b1;
        state_next = S_WAIT_S;
      end
      S_WAIT_S: begin
        if (sqrt_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        sq_ctrl.clear = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sqrt_done) begin
      if (state == S_WAIT_E) begin
        energy_root <= sqrt_root;
      end else begin
        std_root <= sqrt_root;
      end
    end
  end

  scs_sqacc u_sqacc (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (sq_ctrl),
    .operand (sq_operand),
    .acc     (square_sum),
    .acc_sum (acc_sum)
  );

  scs_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_radicand),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Result for the one cycle in S_DONE; zero the values on error
  assign result_ok          = (cur_status == STATUS_OK);
  assign done               = (state == S_DONE);
  assign result.mean_value  = result_ok ? first_value : '0;
  assign result.energy_norm = result_ok ? energy_root : '0;
  assign result.std_dev     = result_ok ? std_root : '0;
  assign result.is_constant = result_ok && (square_sum == '0);
  assign result.status      = cur_status;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an accepted item");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STATUS_OK |->
      result.energy_norm == '0 && result.std_dev == '0 &&
      result.mean_value == '0 && !result.is_constant)
    else $error("error result carries values");

  a_constant_std: assert property (@(posedge clk) disable iff (rst)
    done && result.is_constant |-> result.std_dev == '0)
    else $error("constant set with nonzero deviation");

  a_root_order: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_WAIT_E || state == S_WAIT_S)
    else $error("root finished outside a wait state");

endmodule

/* sim/testbench.sv */
module testbench
  import scs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    FILL_RANDOM,
    FILL_SMALL,
    FILL_EDGE,
    FILL_ZERO
  } fill_t;

  localparam logic signed [COEFF_BITS-1:0] COEFF_MIN = {1'b1, {(COEFF_BITS-1){1'b0}}};
  localparam logic signed [COEFF_BITS-1:0] COEFF_MAX = {1'b0, {(COEFF_BITS-1){1'b1}}};

  // Cycles for the block to finish a set after its last item.
  localparam int SET_LATENCY   = 100;
  localparam int RESULT_WAIT   = 200;
  localparam int RANDOM_ITEMS  = 1400;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  in_item_t                in_data = '0;
  logic                    done;
  out_item_t               result;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_TRUNC_J;
  logic [TRUNC_BITS-1:0]   cfg_data = '0;

  spectral_coefficient_statistics_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Items waiting to be sent, and statistics waiting to come back.
  in_item_t  coeff_queue[$];
  out_item_t expected_stats[$];

  int  fail_count = 0;
  int  idle_pct = 0;      // chance in percent of a sender pause before an item
  bit  item_taken = 1'b0; // set at the rising edge that accepted an item

  // Shadow of the truncation registers and of the running set.
  logic [TRUNC_BITS-1:0]        shadow_j = '0;
  logic [TRUNC_BITS-1:0]        shadow_k = '0;
  logic [TRUNC_BITS-1:0]        shadow_m = '0;
  logic [IDX_BITS-1:0]          set_index = '0;
  logic signed [COEFF_BITS-1:0] set_mean = '0;
  logic [SUM_BITS-1:0]          set_square_sum = '0;
  logic signed [COEFF_BITS-1:0] set_real_hold = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    $display("%s", msg);
  endtask

  function automatic logic [SUM_BITS-1:0] square(input logic signed [COEFF_BITS-1:0] v);
    longint s;
    s = v;
    return SUM_BITS'(s * s);
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[SUM_BITS] ? '1 : t[SUM_BITS-1:0];
  endfunction

  // Floor square root, one result bit per step from the top down.
  function automatic logic [ROOT_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] x);
    logic [ROOT_BITS-1:0] r;
    logic [ROOT_BITS-1:0] trial;
    r = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = r | (ROOT_BITS'(1) << b);
      if ({{ROOT_BITS{1'b0}}, trial} * {{ROOT_BITS{1'b0}}, trial} <= x) r = trial;
    end
    return r;
  endfunction

  // Fold one accepted value into the running set; on the last value queue the
  // statistics the block must report and clear the set.
  task automatic accumulate_coefficient(input in_item_t it);
    logic [IDX_BITS-1:0]   at;
    logic [COUNT_BITS-1:0] count;
    logic [SUM_BITS-1:0]   pair;
    int                    coeff;
    out_item_t             stats;
    at    = set_index;
    coeff = int'(at >> 1);
    count = COUNT_BITS'(at) + 1'b1;
    if (!at[0]) begin
      // Real part: coefficient 0 is the mean, zonal n>=1 counts once.
      if (at == '0) set_mean = it.coeff_value;
      else if (coeff <= int'(shadow_j))
        set_square_sum = sat_sum(set_square_sum, square(it.coeff_value));
      set_real_hold = it.coeff_value;
    end else if (coeff > int'(shadow_j)) begin
      // Imaginary part of an m>0 coefficient: both parts count twice.
      pair = sat_sum(square(set_real_hold), square(it.coeff_value));
      set_square_sum = sat_sum(set_square_sum, pair);
      set_square_sum = sat_sum(set_square_sum, pair);
    end
    if (set_index != IDX_MAX) set_index = set_index + 1'b1;

    if (it.is_last) begin
      stats = '0;
      if (shadow_j != shadow_m || shadow_m != shadow_k) begin
        stats.status = STATUS_UNEQUAL;
      end else if (int'(shadow_m) > MAX_TRUNCATION ||
                   int'(count) != (int'(shadow_m) + 1) * (int'(shadow_m) + 2)) begin
        stats.status = STATUS_COUNT;
      end else begin
        stats.mean_value  = set_mean;
        stats.energy_norm = floor_root(sat_sum(set_square_sum, square(set_mean)));
        stats.std_dev     = floor_root(set_square_sum);
        stats.is_constant = (set_square_sum == '0);
        stats.status      = STATUS_OK;
      end
      expected_stats.push_back(stats);
      set_index      = '0;
      set_mean       = '0;
      set_square_sum = '0;
      set_real_hold  = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got)
      note_failure($sformatf("%0t: %s mismatch, expected %h, actual %h",
                             $time, name, want, got));
  endtask

  // Monitor: mirror register writes, check results, record accepted items.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      item_taken     = 1'b0;
      shadow_j       = '0;
      shadow_k       = '0;
      shadow_m       = '0;
      set_index      = '0;
      set_mean       = '0;
      set_square_sum = '0;
      set_real_hold  = '0;
    end else begin
      item_taken = start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRUNC_J: shadow_j = cfg_data;
          CFG_TRUNC_K: shadow_k = cfg_data;
          CFG_TRUNC_M: shadow_m = cfg_data;
          default: ;
        endcase
      end
      // Results are shown for one cycle only: take them now or lose them.
      if (done) begin
        if (expected_stats.size() == 0) begin
          note_failure($sformatf("%0t: result with none expected, actual %h",
                                 $time, result));
        end else begin
          want = expected_stats.pop_front();
          check_field("mean_value", 32'(want.mean_value), 32'(result.mean_value));
          check_field("energy_norm", want.energy_norm, result.energy_norm);
          check_field("std_dev", want.std_dev, result.std_dev);
          check_field("is_constant", 32'(want.is_constant), 32'(result.is_constant));
          check_field("status", 32'(want.status), 32'(result.status));
        end
      end
      if (item_taken) begin
        accumulate_coefficient(in_data);
        void'(coeff_queue.pop_front());
      end
    end
  end

  // Driver: hold an offered item until taken, otherwise pause at random for
  // a gap counted down in gap_left, or offer the next pending item.
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left = 0;
    end else if (start && !item_taken) begin
      // hold: the block has not taken the item yet
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (coeff_queue.size() == 0) begin
      start <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      gap_left = $urandom_range(0, 6);
      start <= 1'b0;
    end else begin
      start   <= 1'b1;
      in_data <= coeff_queue[0];
    end
  end

  // Write all three truncation registers on consecutive cycles.
  task automatic set_truncation(input int j, input int k, input int m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRUNC_J;
    cfg_data  <= TRUNC_BITS'(j);
    @(negedge clk);
    cfg_index <= CFG_TRUNC_K;
    cfg_data  <= TRUNC_BITS'(k);
    @(negedge clk);
    cfg_index <= CFG_TRUNC_M;
    cfg_data  <= TRUNC_BITS'(m);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Let every pending item go in and every result come out, then give the
  // block time to go quiet. Drop any result that never came as a failure.
  task automatic let_block_settle();
    int waited;
    while (coeff_queue.size() != 0) @(negedge clk);
    waited = 0;
    while (expected_stats.size() != 0 && waited < RESULT_WAIT) begin
      @(negedge clk);
      waited++;
    end
    while (expected_stats.size() != 0) begin
      note_failure($sformatf("%0t: expected result never came, status %0d",
                             $time, expected_stats[0].status));
      void'(expected_stats.pop_front());
    end
    repeat (SET_LATENCY) @(negedge clk);
  endtask

  task automatic push_value(input logic signed [COEFF_BITS-1:0] v, input bit last);
    in_item_t it;
    it.coeff_value = v;
    it.is_last     = last;
    coeff_queue.push_back(it);
  endtask

  function automatic logic signed [COEFF_BITS-1:0] draw_value(input fill_t fill);
    int tmp;
    case (fill)
      FILL_ZERO: return '0;
      FILL_SMALL: begin
        tmp = int'($urandom_range(0, 8191)) - 4096;
        return COEFF_BITS'(tmp);
      end
      FILL_EDGE: begin
        case ($urandom_range(0, 4))
          0: return COEFF_MIN;
          1: return COEFF_MAX;
          2: return '1;
          3: return COEFF_BITS'(1);
          default: return '0;
        endcase
      end
      default: return COEFF_BITS'($urandom);
    endcase
  endfunction

  function automatic fill_t pick_fill();
    case ($urandom_range(0, 9))
      0: return FILL_ZERO;
      1: return FILL_EDGE;
      2, 3: return FILL_SMALL;
      default: return FILL_RANDOM;
    endcase
  endfunction

  // Queue one set of n values. A zero fill keeps a random mean, so the
  // set is constant but its energy is not.
  task automatic queue_set(input int n_values, input fill_t fill);
    for (int i = 0; i < n_values; i++) begin
      if (fill == FILL_ZERO)
        push_value(i == 0 ? draw_value(FILL_RANDOM) : '0, i == n_values - 1);
      else
        push_value(draw_value(fill), i == n_values - 1);
    end
  endtask

  // Set length for truncation m: mostly exact, sometimes a few values off,
  // which also gives odd counts with a dangling real part.
  function automatic int pick_length(input int m);
    int exact;
    int off;
    exact = (m + 1) * (m + 2);
    if ($urandom_range(0, 3) != 0) return exact;
    off = int'($urandom_range(1, 3));
    if ($urandom_range(0, 1) == 0) off = -off;
    return (exact + off < 1) ? 1 : exact + off;
  endfunction

  initial begin
    int j;
    int k;
    int m;
    int n_sets;
    int n_values;
    int random_items;
    bit equal_phase;

    // Reset once.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset truncation is zero, so a set is the mean and one
    // ignored imaginary part. Drive both extremes of the value.
    idle_pct = 0;
    push_value(COEFF_MAX, 1'b0);
    push_value(COEFF_MIN, 1'b1);
    push_value(COEFF_MIN, 1'b0);
    push_value(COEFF_MAX, 1'b1);
    // One lone value: odd and wrong count.
    push_value(COEFF_BITS'(1234), 1'b1);
    let_block_settle();

    // J=K=M=1: mean, ignored imaginary, zonal n=J real once, then one
    // m>0 pair counted twice.
    set_truncation(1, 1, 1);
    push_value('1, 1'b0);
    push_value(COEFF_MAX, 1'b0);
    push_value(COEFF_MIN, 1'b0);
    push_value(COEFF_MAX, 1'b0);
    push_value(COEFF_MAX, 1'b0);
    push_value(COEFF_MIN, 1'b1);
    // Constant set: nonzero mean, every weighted value zero.
    push_value(COEFF_MAX, 1'b0);
    repeat (4) push_value('0, 1'b0);
    push_value('0, 1'b1);
    let_block_settle();

    // Unequal truncations, J off and then K off.
    set_truncation(2, 1, 1);
    push_value(COEFF_BITS'(7), 1'b0);
    push_value(COEFF_BITS'(9), 1'b1);
    let_block_settle();
    set_truncation(1, 2, 1);
    push_value(COEFF_BITS'(7), 1'b0);
    push_value(COEFF_BITS'(9), 1'b1);
    let_block_settle();

    // Random phases: mostly equal small truncations with well-formed sets,
    // the rest unequal settings anywhere in the register range.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      equal_phase = ($urandom_range(0, 9) < 8);
      if (equal_phase) begin
        m = ($urandom_range(0, 3) == 0) ? int'($urandom_range(4, 9))
                                         : int'($urandom_range(0, 3));
        j = m;
        k = m;
      end else begin
        j = int'($urandom_range(0, 63));
        k = int'($urandom_range(0, 63));
        m = int'($urandom_range(0, 63));
        if (j == k && k == m) k = (k + 1) % 64;
      end
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 30;
        default: idle_pct = 60;
      endcase
      set_truncation(j, k, m);
      n_sets = int'($urandom_range(2, 5));
      for (int s = 0; s < n_sets; s++) begin
        n_values = equal_phase ? pick_length(m) : int'($urandom_range(1, 12));
        queue_set(n_values, pick_fill());
        random_items += n_values;
      end
      let_block_settle();
    end

    // Top truncation with a short set of the wrong length.
    idle_pct = 10;
    set_truncation(63, 63, 63);
    queue_set(5, FILL_RANDOM);
    let_block_settle();

    // Closing phase with no pauses.
    idle_pct = 0;
    set_truncation(2, 2, 2);
    repeat (4) queue_set(12, pick_fill());
    let_block_settle();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/scs_pkg.sv
design/scs_sqacc.sv
design/scs_isqrt.sv
design/spectral_coefficient_statistics_top.sv
sim/testbench.sv
